[rtl/swsd_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding window standard deviation package
// Widths, command codes, sequencer states and iteration counts shared by the
// channel interfaces and the standard deviation unit.
// ----------------------------------------------------------------------------
package swsd_pkg;

  // Window and sample geometry.
  localparam int WINDOW_MAX  = 256;
  localparam int SAMPLE_BITS = 24;
  localparam int LEN_W       = 9;
  localparam int SLOT_W      = $clog2(WINDOW_MAX);
  localparam int STD_W       = 23;

  // Running sums: the sum of 256 samples fits 32 bits, the sum of squares 56.
  localparam int SUM_W   = 32;
  localparam int SQSUM_W = 56;

  // Serial arithmetic datapath.
  localparam int MCAND_W = 64;
  localparam int MPL_W   = 32;
  localparam int NSQ_W   = 17;
  localparam int DIVD_W  = 63;
  localparam int ROOT_W  = 32;
  localparam int SREM_W  = 34;
  localparam int CNT_W   = 6;

  // Iterations of each serial step.
  localparam int SQ_STEPS   = SAMPLE_BITS;
  localparam int NMUL_STEPS = LEN_W;
  localparam int SMUL_STEPS = SUM_W;
  localparam int DIV_STEPS  = DIVD_W;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic [LEN_W-1:0] WLEN_RESET = LEN_W'(14);
  localparam logic [STD_W-1:0] STD_MAX    = {STD_W{1'b1}};

  // Input commands; the fourth code acts as a null sample.
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_NULL  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVICT,
    ST_SQ_OLD,
    ST_ADD,
    ST_SQ_NEW,
    ST_CHECK,
    ST_MUL_N,
    ST_MUL_S,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

[rtl/swsd_in_if.sv]
// ----------------------------------------------------------------------------
// Sample channel
// Carries one command and one signed Q12.12 sample per beat.
// ----------------------------------------------------------------------------
interface swsd_in_if import swsd_pkg::*; ();

  logic         valid;
  logic         ready;
  logic [1:0]   cmd;
  sample_t      sample;

  modport source (output valid, cmd, sample, input ready);
  modport sink   (input valid, cmd, sample, output ready);

endinterface

[rtl/swsd_out_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Carries the window standard deviation and its valid flag per beat.
// ----------------------------------------------------------------------------
interface swsd_out_if import swsd_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [STD_W-1:0] stddev;
  logic             result_valid;

  modport source (output valid, stddev, result_valid, input ready);
  modport sink   (input valid, stddev, result_valid, output ready);

endinterface

[rtl/swsd_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration channel
// Carries a new window length per beat.
// ----------------------------------------------------------------------------
interface swsd_cfg_if import swsd_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] window_length;

  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);

endinterface

[rtl/sliding_window_population_stddev_unit.sv]
// ----------------------------------------------------------------------------
// Sliding window population standard deviation unit
// Keeps the last N samples in a ring, tracks their sum and sum of squares,
// and returns floor(sqrt(variance)) of the window for every input beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries a command (add, null, clear) and a sample; every accepted
//   beat yields exactly one beat on out_o with the deviation and a flag that
//   is set once the window holds N samples since the last clear.
//   cfg_i writes the window length N; a write also clears the window.
//   The block takes one item at a time. An add with a full window first
//   evicts the oldest sample, and an add with N nonzero enters its sample
//   into the sums; a valid window then runs the variance arithmetic, else
//   the result is flagged invalid. The work is done by serial arithmetic: a
//   one-bit-per-cycle shift-add multiplier (24, 9 and 32 steps), a restoring
//   divider by N*N at one quotient bit per cycle (63 steps) and a square root
//   at two radicand bits per cycle (32 steps). The result sits in an output
//   register, so the next item is taken while the receiver stalls; a finished
//   item then waits until that register frees up. Reset empties the window,
//   sets N to 14 and drops any result.
// ----------------------------------------------------------------------------
module sliding_window_population_stddev_unit import swsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  swsd_cfg_if.sink   cfg_i,
  swsd_in_if.sink    in_i,
  swsd_out_if.source out_o
);

  // Control state.
  state_e               state_q, state_d;
  logic [LEN_W-1:0]     window_length_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [LEN_W-1:0]     count_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SQSUM_W-1:0]   sqsum_q;
  logic                 out_valid_q;

  // Payload and datapath registers.
  sample_t              sample_q;
  sample_t              window_mem [WINDOW_MAX];
  sample_t              rd_q;
  logic [MCAND_W-1:0]   mcand_q;
  logic [MPL_W-1:0]     mplier_q;
  logic [MCAND_W-1:0]   acc_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIVD_W-1:0]    num_q;
  logic [NSQ_W-1:0]     nsq_q;
  logic [DIVD_W-1:0]    quo_q;
  logic [NSQ_W-1:0]     drem_q;
  logic [SREM_W-1:0]    srem_q;
  logic [ROOT_W-1:0]    root_q;
  logic [STD_W-1:0]     res_sd_q;
  logic                 res_ok_q;
  logic [STD_W-1:0]     out_sd_q;
  logic                 out_ok_q;

  // Combinational helpers.
  logic                 in_acc, cfg_acc, out_acc, out_free;
  logic [LEN_W-1:0]     n_len;
  logic                 win_full, is_valid, last_step;
  logic [MCAND_W-1:0]   mul_add;
  logic [SUM_W-1:0]     sum_mag;
  logic [SAMPLE_BITS-1:0] old_mag, new_mag;
  logic [SUM_W-1:0]     old_ext, new_ext;
  logic [LEN_W-1:0]     slot_inc;
  logic [2*LEN_W-1:0]   nsq_full;
  logic [DIVD_W-1:0]    prod, diff;
  logic [NSQ_W:0]       dtrial;
  logic                 dge;
  logic [NSQ_W-1:0]     drem_d;
  logic [DIVD_W-1:0]    quo_d;
  logic [SREM_W+1:0]    stry;
  logic [SREM_W-1:0]    strial;
  logic                 sge;
  logic [SREM_W-1:0]    srem_d;
  logic [ROOT_W-1:0]    root_d;
  logic [STD_W-1:0]     sd_sat;

  // Handshakes.
  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Effective window length and fill status.
  assign n_len    = (window_length_q > LEN_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX)
                                                           : window_length_q;
  assign win_full = count_q >= n_len;
  assign is_valid = (n_len != '0) && win_full;
  assign last_step = cnt_q == '0;

  // Magnitudes and sign extensions of the evicted and the new sample.
  assign old_mag = rd_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(~rd_q + 1'b1) : rd_q;
  assign new_mag = sample_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample_q + 1'b1) : sample_q;
  assign old_ext = {{(SUM_W-SAMPLE_BITS){rd_q[SAMPLE_BITS-1]}}, rd_q};
  assign new_ext = {{(SUM_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(~sum_q + 1'b1) : sum_q;

  // Next write slot wraps at the window length.
  assign slot_inc = {1'b0, slot_q} + LEN_W'(1);
  assign nsq_full = (2*LEN_W)'(n_len) * (2*LEN_W)'(n_len);

  // One shift-add multiplier step.
  assign mul_add = acc_q + (mplier_q[0] ? mcand_q : '0);

  // Numerator of the scaled variance, clamped at zero.
  assign prod = mul_add[DIVD_W-1:0];
  assign diff = (num_q >= prod) ? num_q - prod : '0;

  // One restoring division step by N*N.
  assign dtrial = {drem_q, quo_q[DIVD_W-1]};
  assign dge    = dtrial >= {1'b0, nsq_q};
  assign drem_d = dge ? NSQ_W'(dtrial - {1'b0, nsq_q}) : dtrial[NSQ_W-1:0];
  assign quo_d  = {quo_q[DIVD_W-2:0], dge};

  // One digit step of the integer square root.
  assign stry   = {srem_q, mcand_q[MCAND_W-1 -: 2]};
  assign strial = {root_q, 2'b01};
  assign sge    = stry >= {2'b00, strial};
  assign srem_d = sge ? SREM_W'(stry - {2'b00, strial}) : stry[SREM_W-1:0];
  assign root_d = {root_q[ROOT_W-2:0], sge};
  assign sd_sat = (root_d[ROOT_W-1:STD_W] != '0) ? STD_MAX : root_d[STD_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.cmd == CMD_ADD && n_len != '0) begin
            state_d = win_full ? ST_EVICT : ST_ADD;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_EVICT:  state_d = ST_SQ_OLD;
      ST_SQ_OLD: if (last_step) state_d = ST_ADD;
      ST_ADD:    state_d = ST_SQ_NEW;
      ST_SQ_NEW: if (last_step) state_d = ST_CHECK;
      ST_CHECK:  state_d = is_valid ? ST_MUL_N : ST_DONE;
      ST_MUL_N:  if (last_step) state_d = ST_MUL_S;
      ST_MUL_S:  if (last_step) state_d = ST_DIV;
      ST_DIV:    if (last_step) state_d = ST_SQRT;
      ST_SQRT:   if (last_step) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    cfg_i.ready        = state_q == ST_IDLE;
    in_i.ready         = (state_q == ST_IDLE) && !cfg_i.valid;
    out_o.valid        = out_valid_q;
    out_o.stddev       = out_sd_q;
    out_o.result_valid = out_ok_q;
  end

  // Control state: window bookkeeping and the output flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      window_length_q <= WLEN_RESET;
      slot_q          <= '0;
      count_q         <= '0;
      sum_q           <= '0;
      sqsum_q         <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        window_length_q <= cfg_i.window_length;
        slot_q          <= '0;
        count_q         <= '0;
        sum_q           <= '0;
        sqsum_q         <= '0;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (in_acc && in_i.cmd == CMD_CLEAR) begin
              slot_q  <= '0;
              count_q <= '0;
              sum_q   <= '0;
              sqsum_q <= '0;
            end
          end
          ST_EVICT: sum_q <= sum_q - old_ext;
          ST_SQ_OLD: begin
            if (last_step) sqsum_q <= sqsum_q - mul_add[SQSUM_W-1:0];
          end
          ST_ADD: sum_q <= sum_q + new_ext;
          ST_SQ_NEW: begin
            if (last_step) begin
              sqsum_q <= sqsum_q + mul_add[SQSUM_W-1:0];
              slot_q  <= (slot_inc >= n_len) ? '0 : slot_inc[SLOT_W-1:0];
              if (count_q < n_len) count_q <= count_q + LEN_W'(1);
            end
          end
          default: ;
        endcase
      end
      // A new result may replace one that leaves in the same cycle.
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sample ring with a registered read port at the current write slot.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ADD) window_mem[slot_q] <= sample_q;
    rd_q <= window_mem[slot_q];
  end

  // Serial arithmetic datapath.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_i.sample;
    end
    unique case (state_q)
      ST_EVICT: begin
        mcand_q  <= MCAND_W'(old_mag);
        mplier_q <= MPL_W'(old_mag);
        acc_q    <= '0;
        cnt_q    <= CNT_W'(SQ_STEPS - 1);
      end
      ST_ADD: begin
        mcand_q  <= MCAND_W'(new_mag);
        mplier_q <= MPL_W'(new_mag);
        acc_q    <= '0;
        cnt_q    <= CNT_W'(SQ_STEPS - 1);
      end
      ST_SQ_OLD, ST_SQ_NEW: begin
        mcand_q  <= {mcand_q[MCAND_W-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
        acc_q    <= mul_add;
        cnt_q    <= cnt_q - CNT_W'(1);
      end
      ST_CHECK: begin
        if (is_valid) begin
          mcand_q  <= MCAND_W'(sqsum_q);
          mplier_q <= MPL_W'(n_len);
          acc_q    <= '0;
          cnt_q    <= CNT_W'(NMUL_STEPS - 1);
          nsq_q    <= nsq_full[NSQ_W-1:0];
        end else begin
          res_sd_q <= '0;
          res_ok_q <= 1'b0;
        end
      end
      ST_MUL_N: begin
        if (last_step) begin
          num_q    <= mul_add[DIVD_W-1:0];
          mcand_q  <= MCAND_W'(sum_mag);
          mplier_q <= sum_mag;
          acc_q    <= '0;
          cnt_q    <= CNT_W'(SMUL_STEPS - 1);
        end else begin
          mcand_q  <= {mcand_q[MCAND_W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
          acc_q    <= mul_add;
          cnt_q    <= cnt_q - CNT_W'(1);
        end
      end
      ST_MUL_S: begin
        if (last_step) begin
          quo_q  <= diff;
          drem_q <= '0;
          cnt_q  <= CNT_W'(DIV_STEPS - 1);
        end else begin
          mcand_q  <= {mcand_q[MCAND_W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
          acc_q    <= mul_add;
          cnt_q    <= cnt_q - CNT_W'(1);
        end
      end
      ST_DIV: begin
        drem_q <= drem_d;
        quo_q  <= quo_d;
        // The quotient becomes the radicand of the square root.
        if (last_step) begin
          mcand_q <= {1'b0, quo_d};
          srem_q  <= '0;
          root_q  <= '0;
          cnt_q   <= CNT_W'(SQRT_STEPS - 1);
        end else begin
          cnt_q   <= cnt_q - CNT_W'(1);
        end
      end
      ST_SQRT: begin
        srem_q  <= srem_d;
        root_q  <= root_d;
        mcand_q <= {mcand_q[MCAND_W-3:0], 2'b00};
        cnt_q   <= cnt_q - CNT_W'(1);
        if (last_step) begin
          res_sd_q <= sd_sat;
          res_ok_q <= 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_sd_q <= res_sd_q;
          out_ok_q <= res_ok_q;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // The fill count never runs past the window length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= n_len)
    else $error("sample count exceeds window length");

  // The write slot stays inside the window.
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_len == '0) || ({1'b0, slot_q} < n_len))
    else $error("write slot outside window");

  // A result that is not valid carries a zero deviation.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.result_valid) |-> (out_o.stddev == '0))
    else $error("invalid result with nonzero deviation");

  // A finished item is handed to the output register and the unit frees up.
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished result not handed to output");
`endif

endmodule
